[hdl/nasa_pkg.sv]
// Shared types and constants of the null-aware stream aggregator.
// Depends on nothing; the other files of the block but nasa_chk.sv refer to it by scoped names.
package nasa_pkg;

	typedef enum logic [2:0] {
		KIND_COUNT_ALL = 3'd0,
		KIND_COUNT_NN  = 3'd1,
		KIND_DISTINCT  = 3'd2,
		KIND_SUM       = 3'd3,
		KIND_MIN       = 3'd4,
		KIND_MAX       = 3'd5,
		KIND_AVG       = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_SCAN,
		ST_FIN,
		ST_DIV,
		ST_EMIT
	} state_t;

	// Requests from the sequencer to the distinct table.
	typedef struct packed {
		logic start;
		logic clear;
	} dist_ctrl_t;

	localparam int unsigned ValueW  = 32;
	localparam int unsigned ResultW = 64;

endpackage

[hdl/nasa_if.sv]
// Handshake channels of the aggregator: the row stream in and the result stream out.
// Depends on nasa_pkg for the field widths.
interface nasa_row_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [nasa_pkg::ValueW-1:0]   value;
	logic                                 is_null;
	logic                                 carries_row;
	logic                                 is_last;

	modport source (output valid, value, is_null, carries_row, is_last, input ready);
	modport sink   (input valid, value, is_null, carries_row, is_last, output ready);
endinterface

interface nasa_res_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [nasa_pkg::ResultW-1:0]  result;
	logic                                 result_null;
	logic                                 distinct_overflow;

	modport source (output valid, result, result_null, distinct_overflow, input ready);
	modport sink   (input valid, result, result_null, distinct_overflow, output ready);
endinterface

[hdl/null_aware_stream_aggregator.sv]
// Sequence: a row that does not end a group goes through ST_ROW back to ST_IDLE; a last beat
// goes on through ST_FIN and ST_EMIT before its result appears. In count-distinct mode a non-null
// row adds a scan of the table, one filled entry per cycle, and an average adds a divider pass.
// Throughput: one beat at a time; the next is taken once the current one is done.
// Reset: arst_n clears the mode, the group state and the table fill count; table contents
// are left undefined and are never read before being written, so no clearing pass is run.
module null_aware_stream_aggregator #(
	parameter int unsigned DISTINCT_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_wdata,
	nasa_row_if.sink     rows,
	nasa_res_if.source   aggr
);

	localparam int unsigned UW = $clog2(DISTINCT_DEPTH + 1);
	localparam int unsigned VW = nasa_pkg::ValueW;
	localparam int unsigned RW = nasa_pkg::ResultW;

	// Mode register and the scalar state of the running group.
	nasa_pkg::kind_t kind_q;
	logic [VW-1:0]   count_q;
	logic [RW-1:0]   acc_q;
	logic            acc_valid_q;

	// The beat being worked on, captured when it is accepted.
	logic [VW-1:0]   value_q;
	logic            is_null_q;
	logic            carries_q;
	logic            last_q;

	// The result being built, and the output register that holds it for the consumer.
	logic [RW-1:0]   res_q;
	logic            res_null_q;
	logic            neg_q;
	logic            out_valid_q;
	logic [RW-1:0]   out_res_q;
	logic            out_null_q;
	logic            out_ovf_q;

	nasa_pkg::state_t state_q, state_d;

	nasa_pkg::dist_ctrl_t dctl;
	logic            dist_done;
	logic [UW-1:0]   dist_used;
	logic            dist_ovf;

	logic            div_start;
	logic            div_done;
	logic [RW-1:0]   quotient;

	logic            accept;
	logic            out_free;
	logic            emit;
	logic            wants_dist;
	logic            avg_ok;
	logic [RW-1:0]   v64;

	assign v64        = {{(RW - VW){value_q[VW-1]}}, value_q};
	assign accept     = rows.valid && rows.ready;
	assign out_free   = !out_valid_q || aggr.ready;
	assign wants_dist = carries_q && !is_null_q && (kind_q == nasa_pkg::KIND_DISTINCT);
	assign avg_ok     = (kind_q == nasa_pkg::KIND_AVG) && acc_valid_q && (count_q != '0);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			nasa_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = nasa_pkg::ST_ROW;
				end
			end
			nasa_pkg::ST_ROW: begin
				if (wants_dist) begin
					state_d = nasa_pkg::ST_SCAN;
				end else if (last_q) begin
					state_d = nasa_pkg::ST_FIN;
				end else begin
					state_d = nasa_pkg::ST_IDLE;
				end
			end
			nasa_pkg::ST_SCAN: begin
				if (dist_done) begin
					state_d = last_q ? nasa_pkg::ST_FIN : nasa_pkg::ST_IDLE;
				end
			end
			nasa_pkg::ST_FIN: begin
				state_d = avg_ok ? nasa_pkg::ST_DIV : nasa_pkg::ST_EMIT;
			end
			nasa_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = nasa_pkg::ST_EMIT;
				end
			end
			nasa_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = nasa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nasa_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		rows.ready = 1'b0;
		dctl       = '0;
		div_start  = 1'b0;
		emit       = 1'b0;
		case (state_q)
			nasa_pkg::ST_IDLE: rows.ready  = 1'b1;
			nasa_pkg::ST_ROW:  dctl.start  = wants_dist;
			nasa_pkg::ST_FIN:  div_start   = avg_ok;
			nasa_pkg::ST_EMIT: begin
				emit       = out_free;
				dctl.clear = out_free;
			end
			default: begin
				rows.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nasa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration: the user must write it only while the block is idle; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= nasa_pkg::KIND_COUNT_ALL;
		end else if (cfg_we) begin
			kind_q <= nasa_pkg::kind_t'(cfg_wdata);
		end
	end

	// Capture of the accepted beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q   <= rows.value;
			is_null_q <= rows.is_null;
			carries_q <= rows.carries_row;
			last_q    <= rows.is_last;
		end
	end

	// Row update of the count and accumulator. The code with no meaning counts all rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			acc_q       <= '0;
			acc_valid_q <= 1'b0;
		end else if (emit) begin
			count_q     <= '0;
			acc_q       <= '0;
			acc_valid_q <= 1'b0;
		end else if (state_q == nasa_pkg::ST_ROW && carries_q) begin
			case (kind_q)
				nasa_pkg::KIND_COUNT_NN: begin
					if (!is_null_q && count_q != '1) begin
						count_q <= count_q + VW'(1);
					end
				end
				nasa_pkg::KIND_DISTINCT: begin
					count_q <= count_q;
				end
				nasa_pkg::KIND_SUM, nasa_pkg::KIND_MIN, nasa_pkg::KIND_MAX,
				nasa_pkg::KIND_AVG: begin
					if (!is_null_q) begin
						if (kind_q == nasa_pkg::KIND_AVG && count_q != '1) begin
							count_q <= count_q + VW'(1);
						end
						acc_valid_q <= 1'b1;
						if (!acc_valid_q) begin
							acc_q <= v64;
						end else if (kind_q == nasa_pkg::KIND_MIN) begin
							if ($signed(v64) < $signed(acc_q)) begin
								acc_q <= v64;
							end
						end else if (kind_q == nasa_pkg::KIND_MAX) begin
							if ($signed(acc_q) < $signed(v64)) begin
								acc_q <= v64;
							end
						end else begin
							acc_q <= acc_q + v64;
						end
					end
				end
				default: begin
					if (count_q != '1) begin
						count_q <= count_q + VW'(1);
					end
				end
			endcase
		end
	end

	// Result selection. The average works on the magnitude and restores the sign afterwards,
	// which gives truncation toward zero.
	always_ff @(posedge clk) begin
		if (state_q == nasa_pkg::ST_FIN) begin
			neg_q      <= acc_q[RW-1];
			res_null_q <= 1'b0;
			case (kind_q)
				nasa_pkg::KIND_DISTINCT: res_q <= RW'(dist_used);
				nasa_pkg::KIND_SUM, nasa_pkg::KIND_MIN, nasa_pkg::KIND_MAX: begin
					res_null_q <= !acc_valid_q;
					res_q      <= acc_valid_q ? acc_q : '0;
				end
				nasa_pkg::KIND_AVG: begin
					res_null_q <= !avg_ok;
					res_q      <= '0;
				end
				default: res_q <= RW'(count_q);
			endcase
		end else if (state_q == nasa_pkg::ST_DIV && div_done) begin
			res_q <= neg_q ? (~quotient + RW'(1)) : quotient;
		end
	end

	// Output register: it frees the input side while a finished result waits to be taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (aggr.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_res_q  <= res_q;
			out_null_q <= res_null_q;
			out_ovf_q  <= dist_ovf;
		end
	end

	assign aggr.valid             = out_valid_q;
	assign aggr.result            = out_res_q;
	assign aggr.result_null       = out_null_q;
	assign aggr.distinct_overflow = out_ovf_q;

	nasa_distinct #(
		.DEPTH (DISTINCT_DEPTH)
	) u_distinct (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (dctl),
		.key      (value_q),
		.done     (dist_done),
		.used     (dist_used),
		.overflow (dist_ovf)
	);

	nasa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc_q[RW-1] ? (~acc_q + RW'(1)) : acc_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (quotient)
	);

endmodule

[hdl/nasa_distinct.sv]
// Distinct-value table: a synchronous memory scanned one entry per cycle, with a fill count.
// Depends on nasa_pkg for the control struct.
module nasa_distinct #(
	parameter int unsigned DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nasa_pkg::dist_ctrl_t            ctrl,
	input  logic [nasa_pkg::ValueW-1:0]     key,
	output logic                            done,
	output logic [$clog2(DEPTH+1)-1:0]      used,
	output logic                            overflow
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned UW = $clog2(DEPTH + 1);

	logic [nasa_pkg::ValueW-1:0] mem [DEPTH];
	logic [nasa_pkg::ValueW-1:0] rd_q;
	logic [nasa_pkg::ValueW-1:0] key_q;
	logic [UW-1:0]               used_q;
	logic [IW-1:0]               idx_q;
	logic                        busy_q;
	logic                        ovf_q;
	logic                        done_q;

	logic                        hit;
	logic                        at_end;
	logic                        rd_en;
	logic [IW-1:0]               rd_addr;
	logic                        ins;
	logic                        wr_en;
	logic [nasa_pkg::ValueW-1:0] wr_data;

	assign hit    = busy_q && (rd_q == key_q);
	assign at_end = (UW'(idx_q) + UW'(1)) >= used_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q + IW'(1);
		ins     = 1'b0;
		wr_data = key_q;
		if (ctrl.start) begin
			rd_addr = '0;
			wr_data = key;
			if (used_q == '0) begin
				ins = 1'b1;
			end else begin
				rd_en = 1'b1;
			end
		end else if (busy_q && !hit) begin
			if (at_end) begin
				ins = 1'b1;
			end else begin
				rd_en = 1'b1;
			end
		end
	end

	assign wr_en = ins && (used_q < UW'(DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[used_q[IW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (ctrl.start) begin
			key_q <= key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			idx_q  <= '0;
			busy_q <= 1'b0;
			ovf_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.clear) begin
				used_q <= '0;
				ovf_q  <= 1'b0;
				busy_q <= 1'b0;
			end else begin
				if (wr_en) begin
					used_q <= used_q + UW'(1);
				end else if (ins) begin
					ovf_q <= 1'b1;
				end
				if (ctrl.start) begin
					idx_q  <= '0;
					busy_q <= (used_q != '0);
					done_q <= (used_q == '0);
				end else if (busy_q) begin
					if (hit || at_end) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
			end
		end
	end

	assign done     = done_q;
	assign used     = used_q;
	assign overflow = ovf_q;

endmodule

[hdl/nasa_div.sv]
// Restoring divider, one quotient bit per cycle: 64-bit magnitude over 32-bit divisor.
// Depends on nasa_pkg for the widths.
module nasa_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [nasa_pkg::ResultW-1:0]     dividend,
	input  logic [nasa_pkg::ValueW-1:0]      divisor,
	output logic                             done,
	output logic [nasa_pkg::ResultW-1:0]     quotient
);

	localparam int unsigned DW = nasa_pkg::ValueW;
	localparam int unsigned QW = nasa_pkg::ResultW;
	localparam int unsigned CW = $clog2(QW);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[QW-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hdl/nasa_chk.sv]
// Port-level checks of the aggregator, attached to the top level by a bind.
// Depends on the top level's channel ports only.
module nasa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] result,
	input logic        result_null
);

	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_null) |-> (result == 64'd0))
		else $error("null result carries a non-zero value");

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again before the previous beat was processed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(result) && $stable(result_null)))
		else $error("stalled result changed");

endmodule

bind null_aware_stream_aggregator nasa_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (rows.valid),
	.in_ready    (rows.ready),
	.out_valid   (aggr.valid),
	.out_ready   (aggr.ready),
	.result      (aggr.result),
	.result_null (aggr.result_null)
);

[tb/nasa_scoreboard.sv]
// Watches the row and result channels of the aggregator, predicts each group result and
// compares it. Depends on nasa_pkg for the mode codes and widths, and on nasa_if.sv.
module nasa_scoreboard #(
	parameter int unsigned DISTINCT_DEPTH = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	nasa_row_if        rows,
	nasa_res_if        aggr,
	output int         errors,
	output int         pending
);

	typedef struct {
		logic signed [nasa_pkg::ResultW-1:0] result;
		logic                                result_null;
		logic                                overflow;
	} group_res_t;

	group_res_t          owed_q[$];
	logic [2:0]          mode;
	logic [31:0]         n_rows;
	logic [63:0]         acc;
	logic                acc_ok;
	logic [31:0]         seen_vals[DISTINCT_DEPTH];
	int unsigned         seen_used;
	logic                dropped;

	assign pending = owed_q.size();

	task automatic clear_group();
		n_rows    = '0;
		acc       = '0;
		acc_ok    = 1'b0;
		seen_used = 0;
		dropped   = 1'b0;
	endtask

	task automatic bump();
		if (n_rows != 32'hFFFF_FFFF) begin
			n_rows = n_rows + 32'd1;
		end
	endtask

	// Folds one row into the group according to the mode current at that row.
	task automatic absorb_row(input logic [31:0] v, input logic nul);
		logic [63:0] wide;
		logic        hit;
		wide = {{32{v[31]}}, v};
		hit  = 1'b0;
		if (mode == nasa_pkg::KIND_COUNT_ALL || mode > nasa_pkg::KIND_AVG) begin
			bump();
		end else if (!nul) begin
			case (mode)
				nasa_pkg::KIND_COUNT_NN: begin
					bump();
				end
				nasa_pkg::KIND_DISTINCT: begin
					for (int i = 0; i < seen_used; i++) begin
						if (seen_vals[i] == v) hit = 1'b1;
					end
					if (!hit) begin
						if (seen_used < DISTINCT_DEPTH) begin
							seen_vals[seen_used] = v;
							seen_used++;
						end else begin
							dropped = 1'b1;
						end
					end
				end
				default: begin
					if (mode == nasa_pkg::KIND_AVG) bump();
					if (!acc_ok) begin
						acc    = wide;
						acc_ok = 1'b1;
					end else if (mode == nasa_pkg::KIND_SUM || mode == nasa_pkg::KIND_AVG) begin
						acc = acc + wide;
					end else if (mode == nasa_pkg::KIND_MIN) begin
						if ($signed(wide) < $signed(acc)) acc = wide;
					end else begin
						if ($signed(wide) > $signed(acc)) acc = wide;
					end
				end
			endcase
		end
	endtask

	function automatic group_res_t close_group();
		group_res_t  r;
		logic [63:0] mag;
		logic [63:0] quo;
		r.result      = '0;
		r.result_null = 1'b0;
		r.overflow    = dropped;
		if (mode == nasa_pkg::KIND_DISTINCT) begin
			r.result = 64'(seen_used);
		end else if (mode >= nasa_pkg::KIND_SUM && mode <= nasa_pkg::KIND_MAX) begin
			r.result_null = !acc_ok;
			r.result      = acc_ok ? acc : '0;
		end else if (mode == nasa_pkg::KIND_AVG) begin
			r.result_null = !acc_ok || n_rows == 0;
			if (!r.result_null) begin
				// Truncation toward zero, done on the magnitude.
				mag      = acc[63] ? -acc : acc;
				quo      = mag / {32'd0, n_rows};
				r.result = acc[63] ? -quo : quo;
			end
		end else begin
			r.result = {32'd0, n_rows};
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		group_res_t want;
		if (!arst_n) begin
			mode   = nasa_pkg::KIND_COUNT_ALL;
			errors = 0;
			owed_q.delete();
			clear_group();
		end else begin
			if (cfg_we) mode = cfg_wdata;
			if (rows.valid && rows.ready) begin
				if (rows.carries_row) absorb_row(rows.value, rows.is_null);
				if (rows.is_last) begin
					owed_q.insert(owed_q.size(), close_group());
					clear_group();
				end
			end
			if (aggr.valid && aggr.ready) begin
				if (owed_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("unexpected result beat: result=%0d null=%b ovf=%b",
							aggr.result, aggr.result_null, aggr.distinct_overflow);
					end
				end else begin
					want = owed_q.pop_front();
					if (aggr.result !== want.result || aggr.result_null !== want.result_null
						|| aggr.distinct_overflow !== want.overflow) begin
						errors++;
						if (errors <= 10) begin
							$display("result mismatch: expected %0d/%b/%b, got %0d/%b/%b",
								want.result, want.result_null, want.overflow,
								aggr.result, aggr.result_null, aggr.distinct_overflow);
						end
					end
				end
			end
		end
	end
endmodule

[tb/tb_null_aware_stream_aggregator.sv]
// Top of the aggregator testbench: clock, reset, row stimulus, result back-pressure, mode
// writes and the verdict. Depends on nasa_pkg, nasa_if.sv and nasa_scoreboard.sv.
module tb_null_aware_stream_aggregator;

	// The spare mode code, which the block must treat as count all.
	localparam logic [2:0] KIND_SPARE = 3'd7;
	// Quiet cycles before a mode write: a full table scan plus the divider, with margin.
	localparam int SETTLE = 400;
	localparam int STALL_LIMIT = 5000;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [2:0] cfg_wdata;
	logic       calm;
	int         errors;
	int         pending;
	int         stall_cycles;

	nasa_row_if rows ();
	nasa_res_if aggr ();

	null_aware_stream_aggregator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rows      (rows),
		.aggr      (aggr)
	);

	nasa_scoreboard sb (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rows      (rows),
		.aggr      (aggr),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The result side stalls in roughly one cycle in five, except during the calm stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aggr.ready <= 1'b0;
		end else begin
			aggr.ready <= calm || ($urandom_range(99) >= 19);
		end
	end

	// The watchdog only counts cycles in which neither channel moves a beat, so long but
	// legitimate table scans and divisions reset it as soon as anything is accepted.
	always @(posedge clk) begin
		if (!arst_n || (rows.valid && rows.ready) || (aggr.valid && aggr.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Sends one beat and returns at the edge where it is taken. The valid line is only
	// lowered when a gap is wanted, so back-to-back beats keep it high without a glitch.
	task automatic put_beat(input logic [31:0] v, input logic nul, input logic row,
		input logic last);
		if (!calm && $urandom_range(99) < 19) begin
			rows.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		rows.valid       <= 1'b1;
		rows.value       <= v;
		rows.is_null     <= nul;
		rows.carries_row <= row;
		rows.is_last     <= last;
		@(posedge clk);
		while (!rows.ready) @(posedge clk);
	endtask

	// Drains every owed result, lets the block finish any trailing scan, then writes the
	// mode. The sender stays silent throughout, which also gives the full-drain pause.
	task automatic set_mode(input logic [2:0] k);
		rows.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Values lean towards the extremes and a small range, so that repeats (which matter for
	// count distinct) and min/max ties occur often, with plain random words in between.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'd0;
			3:       return 32'hFFFF_FFFF;
			4, 5, 6: return $urandom_range(15) - 8;
			default: return $urandom;
		endcase
	endfunction

	// One group of random rows; it ends either on a last row or on an empty end marker, and
	// now and then carries a stray end marker that is not last, which must change nothing.
	task automatic random_group();
		int n;
		n = $urandom_range(0, 10);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0) begin
				put_beat($urandom, 1'($urandom_range(1)), 1'b0, 1'b0);
			end
			put_beat(pick_value(), $urandom_range(3) == 0, 1'b1, 1'b0);
		end
		if ($urandom_range(2) == 0) begin
			put_beat($urandom, 1'($urandom_range(1)), 1'b0, 1'b1);
		end else begin
			put_beat(pick_value(), $urandom_range(3) == 0, 1'b1, 1'b1);
		end
	endtask

	initial begin
		logic [2:0] kinds[8];
		int         sent;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		calm             = 1'b0;
		rows.valid       = 1'b0;
		rows.value       = '0;
		rows.is_null     = 1'b0;
		rows.carries_row = 1'b0;
		rows.is_last     = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Count all straight out of reset: nulls and extremes all count, and
		// an empty group closed by a bare end marker gives zero.
		put_beat(32'h8000_0000, 1'b0, 1'b1, 1'b0);
		put_beat(32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0);
		put_beat(32'd0, 1'b0, 1'b0, 1'b0);
		put_beat(32'd0, 1'b0, 1'b1, 1'b1);
		put_beat(32'd0, 1'b0, 1'b0, 1'b1);

		// Sum of the positive extreme twice and of all ones; then a group of nulls only, which is NULL.
		set_mode(nasa_pkg::KIND_SUM);
		put_beat(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0);
		put_beat(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0);
		put_beat(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1);
		put_beat(32'h1234_5678, 1'b1, 1'b1, 1'b1);

		// Mode change inside a group: rows summed, then the group is closed as a maximum.
		put_beat(32'd5, 1'b0, 1'b1, 1'b0);
		put_beat(32'd7, 1'b0, 1'b1, 1'b0);
		set_mode(nasa_pkg::KIND_MAX);
		put_beat(32'h8000_0000, 1'b0, 1'b1, 1'b1);

		// Minimum over both extremes; average of negatives truncates toward zero.
		set_mode(nasa_pkg::KIND_MIN);
		put_beat(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0);
		put_beat(32'h8000_0000, 1'b0, 1'b1, 1'b1);
		set_mode(nasa_pkg::KIND_AVG);
		put_beat(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
		put_beat(32'hFFFF_FFFE, 1'b0, 1'b1, 1'b1);
		put_beat(32'd0, 1'b1, 1'b1, 1'b1);

		// Count non-null and the spare code, which behaves as count all.
		set_mode(nasa_pkg::KIND_COUNT_NN);
		put_beat(32'd1, 1'b1, 1'b1, 1'b0);
		put_beat(32'd1, 1'b0, 1'b1, 1'b1);
		set_mode(KIND_SPARE);
		put_beat(32'd1, 1'b1, 1'b1, 1'b1);

		// Count distinct past the table size: the table fills, the rest are dropped and the
		// overflow flag rises. A repeat and a null are mixed in, and neither may count.
		set_mode(nasa_pkg::KIND_DISTINCT);
		calm = 1'b1;
		put_beat(32'd3, 1'b0, 1'b1, 1'b0);
		put_beat(32'd3, 1'b0, 1'b1, 1'b0);
		put_beat(32'd9, 1'b1, 1'b1, 1'b0);
		for (int i = 0; i < 262; i++) begin
			put_beat(32'h8000_0000 + i * 32'd40503, 1'b0, 1'b1, i == 261);
		end
		calm = 1'b0;
		// The flag must be cleared for the next group.
		put_beat(32'd3, 1'b0, 1'b1, 1'b1);

		// Random part: every mode including the spare code, with the extremes 0 and 7 among
		// them, each in a phase of random groups. One phase runs without any idling.
		kinds = '{nasa_pkg::KIND_COUNT_ALL, nasa_pkg::KIND_COUNT_NN, nasa_pkg::KIND_DISTINCT,
			nasa_pkg::KIND_SUM, nasa_pkg::KIND_MIN, nasa_pkg::KIND_MAX, nasa_pkg::KIND_AVG,
			KIND_SPARE};
		for (int p = 0; p < 8; p++) begin
			set_mode(kinds[p]);
			calm = (p == 5);
			sent = 0;
			while (sent < 12) begin
				random_group();
				sent += 6;
			end
		end
		calm = 1'b0;

		rows.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
